// ===== rtl/hob_pkg.sv =====
// Shared constants, types and arithmetic helpers of the halo outline builder.
`timescale 1ns / 1ps

package hob_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int HALO       = 2;
    localparam int PAD        = 2;

    localparam int CH_W      = 8;
    localparam int DIM_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;
    localparam int OFF_N     = 2 * HALO + 1;
    localparam int OFF_W     = $clog2(OFF_N);
    localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CRD_W     = DIM_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TINT_RED     = 3'd0,
        CFG_TINT_GREEN   = 3'd1,
        CFG_TINT_BLUE    = 3'd2,
        CFG_IMAGE_WIDTH  = 3'd3,
        CFG_IMAGE_HEIGHT = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_READ = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    // Rounded 8-bit product as used by the compositing operators.
    function automatic logic [CH_W-1:0] mul8(input logic [CH_W-1:0] a,
                                             input logic [CH_W-1:0] b);
        logic [16:0] u;
        logic [16:0] v;
        begin
            u = 17'(a) * 17'(b) + 17'd128;
            v = (u + (u >> 8)) >> 8;
            return v[CH_W-1:0];
        end
    endfunction

    // Exact truncating division of a 16-bit product of two bytes by 255.
    function automatic logic [CH_W-1:0] div255(input logic [15:0] p);
        logic [16:0] v;
        begin
            v = (17'(p) + 17'd1 + 17'(p >> 8)) >> 8;
            return v[CH_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/halo_outline_builder.sv =====
// Top level of the halo outline builder: alpha store, neighbourhood sequencer and compositor.
`timescale 1ns / 1ps

// Channel        | Direction | Contents
// ---------------+-----------+----------------------------------------------------------
// s_t*           | in        | tuser: req_type; tdata: x_coord, y_coord, src_alpha
// m_t*           | out       | tdata: out_blue, out_green, out_red, out_alpha
// cfg_*          | in        | register writes: tint_red/green/blue, image_width/height
//
// A load transaction writes the alpha store directly.
// A read transaction is accepted, issues 25 alpha store reads (one per halo offset,
// the centre last), drains the pipeline and is handed over to the result register.
// The single read port of the alpha store serialises these reads.
// Reads outside the padded image skip the walk and return zero.
// Reset clears the control state and restores the register defaults; the store is not cleared.
// The result register holds its transaction while m_tready is low; loads and the next read
// are still taken, but a read that finishes meanwhile waits in the hand-over state and
// blocks the input until the result register is free.

module halo_outline_builder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // x_coord[6:0], y_coord[13:7], src_alpha[21:14], zero
    input  logic                            s_tuser,   // req_type[0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // out_blue, out_green, out_red, out_alpha
    input  logic                            cfg_we,
    input  logic [hob_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hob_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import hob_pkg::*;

    // Configuration registers.
    logic [CH_W-1:0]  tint_red_reg, tint_green_reg, tint_blue_reg;
    logic [DIM_W-1:0] image_width_reg, image_height_reg;

    // Sequencer control.
    state_t           state_reg, state_next;
    logic [OFF_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic             cen_reg, cen_next;

    // Read transaction coordinates.
    logic [DIM_W-1:0] x_reg, y_reg;

    // Pipeline: stage one carries the store read, stage two the tinted source pixel.
    logic             p1_valid_reg, p1_inimg_reg, p1_centre_reg;
    logic             p2_valid_reg, p2_centre_reg;
    logic [CH_W-1:0]  s_reg [4];
    logic [CH_W-1:0]  d_reg [4];
    logic [CH_W-1:0]  d_next [4];

    // Result register.
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      out_data_reg;

    // Alpha store.
    logic [CH_W-1:0]  mem [MEM_DEPTH];
    logic [CH_W-1:0]  rdata_reg;
    logic             mem_we, mem_re;
    logic [ADDR_W-1:0] waddr, raddr;

    // Input field decode.
    logic [DIM_W-1:0] x_in, y_in;
    logic [CH_W-1:0]  a_in;
    logic             in_acc, is_load, is_read, read_active;
    logic [DIM_W-1:0] w_eff, h_eff;

    // Offset and coordinate arithmetic.
    logic signed [CRD_W-1:0] sx, sy;
    logic             inimg;
    logic             flush_go;
    logic [CH_W-1:0]  a_eff;

    assign x_in = s_tdata[6:0];
    assign y_in = s_tdata[13:7];
    assign a_in = s_tdata[21:14];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign is_load  = in_acc && (s_tuser == REQ_LOAD);
    assign is_read  = in_acc && (s_tuser == REQ_READ);

    // Image size limited to the store's extent.
    assign w_eff = (32'(image_width_reg)  > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : image_width_reg;
    assign h_eff = (32'(image_height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : image_height_reg;

    // A read inside the padded image walks the neighbourhood; anything else returns zero.
    assign read_active = (w_eff != '0) && (h_eff != '0)
                      && ({1'b0, x_in} < {1'b0, w_eff} + (DIM_W+1)'(2 * PAD))
                      && ({1'b0, y_in} < {1'b0, h_eff} + (DIM_W+1)'(2 * PAD));

    // Load path: writes outside the store are dropped.
    assign mem_we = is_load && (32'(x_in) < MAX_WIDTH) && (32'(y_in) < MAX_HEIGHT);
    assign waddr  = ADDR_W'(32'(y_in) * MAX_WIDTH + 32'(x_in));

    // Source pixel for the current offset: (x - PAD - ox, y - PAD - oy) with ox = ox_reg - HALO.
    assign sx = $signed({2'b00, x_reg}) + signed'(CRD_W'(HALO - PAD))
              - $signed({{(CRD_W-OFF_W){1'b0}}, ox_reg});
    assign sy = $signed({2'b00, y_reg}) + signed'(CRD_W'(HALO - PAD))
              - $signed({{(CRD_W-OFF_W){1'b0}}, oy_reg});

    assign inimg = !sx[CRD_W-1] && !sy[CRD_W-1]
                && (sx[CRD_W-2:0] < (CRD_W-1)'(w_eff))
                && (sy[CRD_W-2:0] < (CRD_W-1)'(h_eff));

    assign mem_re = (state_reg == ST_RUN);
    assign raddr  = ADDR_W'(32'(sy[CRD_W-2:0]) * MAX_WIDTH + 32'(sx[CRD_W-2:0]));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= a_in;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign flush_go = (state_reg == ST_FLUSH) && (!out_valid_reg || m_tready);

    // Sequencer: walks the offsets with the vertical one outer, skips the centre and
    // issues the centre last, for the final erase step.
    always_comb
    begin
        state_next = state_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        cen_next   = cen_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_read)
                begin
                    ox_next    = '0;
                    oy_next    = '0;
                    cen_next   = 1'b0;
                    state_next = read_active ? ST_RUN : ST_FLUSH;
                end
            end
            ST_RUN:
            begin
                if (cen_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else if ((ox_reg == OFF_W'(OFF_N - 1)) && (oy_reg == OFF_W'(OFF_N - 1)))
                begin
                    ox_next  = OFF_W'(HALO);
                    oy_next  = OFF_W'(HALO);
                    cen_next = 1'b1;
                end
                else if (ox_reg == OFF_W'(OFF_N - 1))
                begin
                    ox_next = '0;
                    oy_next = oy_reg + 1'b1;
                end
                else if ((ox_reg == OFF_W'(HALO - 1)) && (oy_reg == OFF_W'(HALO)))
                begin
                    ox_next = OFF_W'(HALO + 1);
                end
                else
                begin
                    ox_next = ox_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (p2_valid_reg && p2_centre_reg)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (flush_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Compositing step: each shifted copy is laid over the result, and the centre copy
    // then erases the result where the source itself is opaque.
    always_comb
    begin
        logic [CH_W-1:0] m;
        logic [CH_W:0]   v;
        for (int c = 0; c < 4; c++)
        begin
            m = mul8(d_reg[c], 8'd255 - s_reg[3]);
            v = {1'b0, s_reg[c]} + {1'b0, m};
            if (p2_centre_reg)
            begin
                d_next[c] = m;
            end
            else
            begin
                d_next[c] = v[CH_W] ? 8'd255 : v[CH_W-1:0];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (flush_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign a_eff = p1_inimg_reg ? rdata_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ox_reg           <= '0;
            oy_reg           <= '0;
            cen_reg          <= 1'b0;
            p1_valid_reg     <= 1'b0;
            p2_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            tint_red_reg     <= 8'd255;
            tint_green_reg   <= 8'd255;
            tint_blue_reg    <= 8'd255;
            image_width_reg  <= DIM_W'(64);
            image_height_reg <= DIM_W'(64);
        end
        else
        begin
            state_reg     <= state_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            cen_reg       <= cen_next;
            p1_valid_reg  <= mem_re;
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TINT_RED:     tint_red_reg     <= cfg_data;
                    CFG_TINT_GREEN:   tint_green_reg   <= cfg_data;
                    CFG_TINT_BLUE:    tint_blue_reg    <= cfg_data;
                    CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (is_read)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
        end
        p1_inimg_reg  <= inimg;
        p1_centre_reg <= cen_reg;
        p2_centre_reg <= p1_centre_reg;
        s_reg[0] <= div255(16'(a_eff) * 16'(tint_blue_reg));
        s_reg[1] <= div255(16'(a_eff) * 16'(tint_green_reg));
        s_reg[2] <= div255(16'(a_eff) * 16'(tint_red_reg));
        s_reg[3] <= a_eff;
        for (int c = 0; c < 4; c++)
        begin
            if (is_read)
            begin
                d_reg[c] <= '0;
            end
            else if (p2_valid_reg)
            begin
                d_reg[c] <= d_next[c];
            end
        end
        if (flush_go)
        begin
            out_data_reg <= {d_reg[3], d_reg[2], d_reg[1], d_reg[0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The erase step only ever arrives once all reads have been issued.
    a_centre_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (p2_valid_reg && p2_centre_reg) |-> (state_reg == ST_DRAIN))
        else $error("centre pixel composited outside the drain phase");

    // The walk ends only through the drain phase.
    a_run_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |=> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("neighbourhood walk left abruptly");

    // A new result appears only from the hand-over state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FLUSH))
        else $error("result raised outside the hand-over state");

    // A waiting read hands over as soon as the result register is free.
    a_flush_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && !out_valid_reg) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished read not handed over");

endmodule
